// File: rtl/core/rec_pkg.sv
// ----------------------------------------------------------------------------
// rec_pkg: shared definitions for the range encoder
// Field widths, coder constants, operation codes and the arithmetic unit's
// request and result types.
// ----------------------------------------------------------------------------
package rec_pkg;

    // field widths
    localparam int SYMBOL_BITS = 8;
    localparam int CODE_BITS   = 32;
    localparam int FREQ_BITS   = 16;
    localparam int LOG2_BITS   = 4;
    localparam int OP_BITS     = 2;
    localparam int COUNT_BITS  = 32;

    // coder constants
    localparam logic [CODE_BITS-1:0]   CODE_TOP = 32'h8000_0000;
    localparam logic [CODE_BITS-1:0]   CODE_BOT = 32'h0080_0000;
    localparam logic [CODE_BITS-1:0]   LOW_MASK = 32'h7FFF_FFFF;
    localparam logic [SYMBOL_BITS-1:0] SYM_MAX  = 8'hFF;
    localparam logic [SYMBOL_BITS-1:0] SYM_ZERO = 8'h00;
    localparam logic [2:0]             RENORM_STEPS = 3'd4;

    // operation codes
    localparam logic [OP_BITS-1:0] OP_ENC_FREQ = 2'd0;
    localparam logic [OP_BITS-1:0] OP_ENC_POW2 = 2'd1;
    localparam logic [OP_BITS-1:0] OP_FINISH   = 2'd2;

    // shared arithmetic unit
    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,
        ALU_SUB = 2'd1,
        ALU_MUL = 2'd2
    } alu_op_t;

    typedef struct packed {
        alu_op_t              op;
        logic [CODE_BITS-1:0] a;
        logic [CODE_BITS-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [CODE_BITS-1:0] value;
        logic                 ge;
    } alu_res_t;

endpackage

// File: rtl/core/rec_item_if.sv
// ----------------------------------------------------------------------------
// rec_item_if: input channel of the range encoder
// One transfer carries one symbol to encode or a finish request.
// ----------------------------------------------------------------------------
interface rec_item_if;

    logic                          valid;
    logic                          ready;
    logic [rec_pkg::OP_BITS-1:0]   op;
    logic [rec_pkg::FREQ_BITS-1:0] low_freq;
    logic [rec_pkg::FREQ_BITS-1:0] high_freq;
    logic [rec_pkg::FREQ_BITS-1:0] total_freq;
    logic [rec_pkg::LOG2_BITS-1:0] total_log2;

    modport source (
        output valid, op, low_freq, high_freq, total_freq, total_log2,
        input  ready
    );

    modport sink (
        input  valid, op, low_freq, high_freq, total_freq, total_log2,
        output ready
    );

endinterface

// File: rtl/core/rec_result_if.sv
// ----------------------------------------------------------------------------
// rec_result_if: output channel of the range encoder
// One transfer carries one byte value with a repeat count.
// ----------------------------------------------------------------------------
interface rec_result_if;

    logic                            valid;
    logic                            ready;
    logic [rec_pkg::SYMBOL_BITS-1:0] byte_value;
    logic [rec_pkg::COUNT_BITS-1:0]  repeat_count;
    logic                            last;

    modport source (
        output valid, byte_value, repeat_count, last,
        input  ready
    );

    modport sink (
        input  valid, byte_value, repeat_count, last,
        output ready
    );

endinterface

// File: rtl/core/rec_alu.sv
// ----------------------------------------------------------------------------
// rec_alu: shared arithmetic unit of the range encoder
// Add, subtract with unsigned compare, and a 32 by 16 multiply kept to 32 bits.
// ----------------------------------------------------------------------------
module rec_alu (
    input  rec_pkg::alu_req_t req,
    output rec_pkg::alu_res_t res
);

    logic [rec_pkg::CODE_BITS:0]                    diff;
    logic [rec_pkg::CODE_BITS+rec_pkg::FREQ_BITS-1:0] prod;

    // subtract with borrow out, and the narrow multiply
    assign diff = {1'b0, req.a} - {1'b0, req.b};
    assign prod = req.a * req.b[rec_pkg::FREQ_BITS-1:0];

    // operation select
    always_comb
    begin
        res = '0;
        unique case (req.op)
            rec_pkg::ALU_ADD:
            begin
                res.value = req.a + req.b;
            end
            rec_pkg::ALU_SUB:
            begin
                res.value = diff[rec_pkg::CODE_BITS-1:0];
                res.ge    = ~diff[rec_pkg::CODE_BITS];
            end
            rec_pkg::ALU_MUL:
            begin
                res.value = prod[rec_pkg::CODE_BITS-1:0];
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

endmodule

// File: rtl/core/range_encoder_carry_buffered.sv
// ----------------------------------------------------------------------------
// range_encoder_carry_buffered: byte-oriented 32-bit range encoder
// Sequencer around one shared add/subtract/multiply unit, with a carry
// buffer of one held byte and a count of pending 0xFF bytes.
// ----------------------------------------------------------------------------
// Usage
//   item   : one transfer per symbol (op 0 frequency total, op 1 power-of-two
//            total) or per finish request (op 2). Invalid operands and op 3
//            are taken and give nothing.
//   result : byte_value with repeat_count copies; a run of pending 0xFF or
//            0x00 bytes comes as one transfer. last marks the final byte of
//            a finish.
//   Timing : ready is high only while the sequencer is idle. An op 0 symbol
//            runs the restoring divide (one quotient bit per cycle) and up
//            to two multiplies, op 1 only the multiplies, and each symbol
//            ends with up to four renormalisation steps. A finish runs a
//            leading-zero search and then pushes each tail byte.
//   Stall  : results sit in one output register; the sequencer waits in an
//            emit state while that register is full and not taken.
//   Reset  : clears the coder to low 0, range 0x80000000, empty buffer.
//            The same state returns after each finish.
// ----------------------------------------------------------------------------
module range_encoder_carry_buffered (
    input  logic          clk,
    input  logic          rst_n,
    rec_item_if.sink      item,
    rec_result_if.source  result
);

    typedef enum logic [18:0] {
        S_IDLE       = 19'h00001,
        S_DIV        = 19'h00002,
        S_MUL1       = 19'h00004,
        S_SUB1       = 19'h00008,
        S_ADD1       = 19'h00010,
        S_MUL2       = 19'h00020,
        S_RENORM     = 19'h00040,
        S_PUSH       = 19'h00080,
        S_EMIT_HELD  = 19'h00100,
        S_EMIT_RUN   = 19'h00200,
        S_RETURN     = 19'h00400,
        S_CLZ        = 19'h00800,
        S_MASK       = 19'h01000,
        S_HIGH       = 19'h02000,
        S_CHECK      = 19'h04000,
        S_REMASK     = 19'h08000,
        S_TAIL_LOOP  = 19'h10000,
        S_TAIL_FLUSH = 19'h20000,
        S_CLEAR      = 19'h40000
    } state_t;

    // who called the byte push
    typedef enum logic [1:0] {
        CTX_RENORM = 2'd0,
        CTX_LOOP   = 2'd1,
        CTX_TAIL   = 2'd2
    } ctx_t;

    localparam int CB = rec_pkg::CODE_BITS;
    localparam int SB = rec_pkg::SYMBOL_BITS;
    localparam int FB = rec_pkg::FREQ_BITS;

    state_t            state_reg, state_next;
    ctx_t              ctx_reg, ctx_next;
    logic [CB-1:0]     low_reg, low_next;
    logic [CB-1:0]     range_reg, range_next;
    logic [SB-1:0]     held_reg, held_next;
    logic              held_valid_reg, held_valid_next;
    logic [CB-1:0]     pending_reg, pending_next;
    logic [CB-1:0]     quo_reg, quo_next;
    logic [FB-1:0]     rem_reg, rem_next;
    logic [CB-1:0]     tmp_reg, tmp_next;
    logic [CB-1:0]     end_reg, end_next;
    logic [CB-1:0]     msk_reg, msk_next;
    logic [5:0]        len_reg, len_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic [2:0]        guard_reg, guard_next;
    logic [SB:0]       c_reg, c_next;
    logic [FB-1:0]     ft_reg, ft_next;
    logic [FB-1:0]     k1_reg, k1_next;
    logic [FB-1:0]     k2_reg, k2_next;
    logic              fl_nz_reg, fl_nz_next;
    logic              ovalid_reg, ovalid_next;
    logic [SB-1:0]     obyte_reg, obyte_next;
    logic [CB-1:0]     ocount_reg, ocount_next;
    logic              olast_reg, olast_next;

    rec_pkg::alu_req_t alu_req;
    rec_pkg::alu_res_t alu_res;

    logic              accept;
    logic              slot_free;
    logic [FB-1:0]     pow2_total;
    logic [FB-1:0]     sel_total;
    logic              item_ok;
    logic [CB-1:0]     mask_from_len;
    logic [FB:0]       trial;

    // shared arithmetic unit
    rec_alu u_alu (
        .req (alu_req),
        .res (alu_res)
    );

    // handshake and small helpers
    assign accept        = item.valid && item.ready;
    assign item.ready    = (state_reg == S_IDLE);
    assign slot_free     = !ovalid_reg || result.ready;
    assign pow2_total    = FB'(1) << item.total_log2;
    assign sel_total     = (item.op == rec_pkg::OP_ENC_FREQ) ? item.total_freq : pow2_total;
    assign item_ok       = (sel_total != '0) && (item.high_freq > item.low_freq)
                           && (item.high_freq <= sel_total);
    assign mask_from_len = rec_pkg::LOW_MASK >> len_reg[4:0];
    assign trial         = {rem_reg, quo_reg[CB-1]};

    assign result.valid        = ovalid_reg;
    assign result.byte_value   = obyte_reg;
    assign result.repeat_count = ocount_reg;
    assign result.last         = olast_reg;

    // operand select for the shared unit
    always_comb
    begin
        alu_req.op = rec_pkg::ALU_ADD;
        alu_req.a  = low_reg;
        alu_req.b  = mask_from_len;
        unique case (state_reg)
            S_DIV:
            begin
                alu_req.op = rec_pkg::ALU_SUB;
                alu_req.a  = CB'(trial);
                alu_req.b  = CB'(ft_reg);
            end
            S_MUL1:
            begin
                alu_req.op = rec_pkg::ALU_MUL;
                alu_req.a  = quo_reg;
                alu_req.b  = CB'(k1_reg);
            end
            S_SUB1:
            begin
                alu_req.op = rec_pkg::ALU_SUB;
                alu_req.a  = range_reg;
                alu_req.b  = tmp_reg;
            end
            S_ADD1:
            begin
                alu_req.a  = low_reg;
                alu_req.b  = tmp_reg;
            end
            S_MUL2:
            begin
                alu_req.op = rec_pkg::ALU_MUL;
                alu_req.a  = quo_reg;
                alu_req.b  = CB'(k2_reg);
            end
            S_HIGH:
            begin
                alu_req.a  = low_reg;
                alu_req.b  = range_reg;
            end
            S_CHECK:
            begin
                alu_req.op = rec_pkg::ALU_SUB;
                alu_req.a  = end_reg | msk_reg;
                alu_req.b  = tmp_reg;
            end
            S_REMASK:
            begin
                alu_req.a  = low_reg;
                alu_req.b  = msk_reg;
            end
            default:
            begin
                alu_req.op = rec_pkg::ALU_ADD;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        ctx_next        = ctx_reg;
        low_next        = low_reg;
        range_next      = range_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        pending_next    = pending_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        tmp_next        = tmp_reg;
        end_next        = end_reg;
        msk_next        = msk_reg;
        len_next        = len_reg;
        cnt_next        = cnt_reg;
        guard_next      = guard_reg;
        c_next          = c_reg;
        ft_next         = ft_reg;
        k1_next         = k1_reg;
        k2_next         = k2_reg;
        fl_nz_next      = fl_nz_reg;
        ovalid_next     = ovalid_reg && !result.ready;
        obyte_next      = obyte_reg;
        ocount_next     = ocount_reg;
        olast_next      = olast_reg;

        unique case (state_reg)
            // take an item and set up its operands
            S_IDLE:
            begin
                if (accept)
                begin
                    ft_next    = sel_total;
                    fl_nz_next = (item.low_freq != '0);
                    k1_next    = (item.low_freq != '0) ? sel_total - item.low_freq
                                                       : sel_total - item.high_freq;
                    k2_next    = item.high_freq - item.low_freq;
                    if (item.op == rec_pkg::OP_FINISH)
                    begin
                        quo_next   = range_reg;
                        len_next   = '0;
                        state_next = S_CLZ;
                    end
                    else if (item.op == rec_pkg::OP_ENC_FREQ && item_ok)
                    begin
                        quo_next   = range_reg;
                        rem_next   = '0;
                        cnt_next   = '0;
                        state_next = S_DIV;
                    end
                    else if (item.op == rec_pkg::OP_ENC_POW2 && item_ok)
                    begin
                        quo_next   = range_reg >> item.total_log2;
                        state_next = S_MUL1;
                    end
                end
            end
            // restoring divide, one quotient bit per cycle
            S_DIV:
            begin
                if (alu_res.ge)
                begin
                    rem_next = alu_res.value[FB-1:0];
                    quo_next = {quo_reg[CB-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[FB-1:0];
                    quo_next = {quo_reg[CB-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(CB - 1))
                begin
                    state_next = S_MUL1;
                end
            end
            S_MUL1:
            begin
                tmp_next   = alu_res.value;
                state_next = S_SUB1;
            end
            S_SUB1:
            begin
                if (fl_nz_reg)
                begin
                    tmp_next   = alu_res.value;
                    state_next = S_ADD1;
                end
                else
                begin
                    range_next = alu_res.value;
                    guard_next = '0;
                    state_next = S_RENORM;
                end
            end
            S_ADD1:
            begin
                low_next   = alu_res.value;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                range_next = alu_res.value;
                guard_next = '0;
                state_next = S_RENORM;
            end
            // renormalisation step test
            S_RENORM:
            begin
                if (range_reg <= rec_pkg::CODE_BOT && guard_reg != rec_pkg::RENORM_STEPS)
                begin
                    c_next     = low_reg[CB-1:CB-SB-1];
                    ctx_next   = CTX_RENORM;
                    state_next = S_PUSH;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            // carry buffer: decide what leaves
            S_PUSH:
            begin
                if (c_reg != {1'b0, rec_pkg::SYM_MAX})
                begin
                    if (held_valid_reg)
                    begin
                        state_next = S_EMIT_HELD;
                    end
                    else if (pending_reg != '0)
                    begin
                        state_next = S_EMIT_RUN;
                    end
                    else
                    begin
                        pending_next    = '0;
                        held_next       = c_reg[SB-1:0];
                        held_valid_next = 1'b1;
                        state_next      = S_RETURN;
                    end
                end
                else
                begin
                    if (pending_reg != '1)
                    begin
                        pending_next = pending_reg + CB'(1);
                    end
                    state_next = S_RETURN;
                end
            end
            S_EMIT_HELD:
            begin
                if (slot_free)
                begin
                    ovalid_next = 1'b1;
                    obyte_next  = held_reg + SB'(c_reg[SB]);
                    ocount_next = CB'(1);
                    olast_next  = (ctx_reg == CTX_TAIL) && (pending_reg == '0);
                    if (pending_reg != '0)
                    begin
                        state_next = S_EMIT_RUN;
                    end
                    else
                    begin
                        held_next       = c_reg[SB-1:0];
                        held_valid_next = 1'b1;
                        state_next      = S_RETURN;
                    end
                end
            end
            S_EMIT_RUN:
            begin
                if (slot_free)
                begin
                    ovalid_next     = 1'b1;
                    obyte_next      = c_reg[SB] ? rec_pkg::SYM_ZERO : rec_pkg::SYM_MAX;
                    ocount_next     = pending_reg;
                    olast_next      = (ctx_reg == CTX_TAIL);
                    pending_next    = '0;
                    held_next       = c_reg[SB-1:0];
                    held_valid_next = 1'b1;
                    state_next      = S_RETURN;
                end
            end
            // back to whoever pushed the byte
            S_RETURN:
            begin
                unique case (ctx_reg)
                    CTX_RENORM:
                    begin
                        low_next   = {1'b0, low_reg[CB-SB-2:0], SB'(0)};
                        range_next = {range_reg[CB-SB-1:0], SB'(0)};
                        guard_next = guard_reg + 3'd1;
                        state_next = S_RENORM;
                    end
                    CTX_LOOP:
                    begin
                        end_next   = {1'b0, end_reg[CB-SB-2:0], SB'(0)};
                        len_next   = (len_reg > 6'(SB)) ? len_reg - 6'(SB) : '0;
                        state_next = S_TAIL_LOOP;
                    end
                    CTX_TAIL:
                    begin
                        state_next = S_CLEAR;
                    end
                    default:
                    begin
                        state_next = S_CLEAR;
                    end
                endcase
            end
            // leading-zero count of the range, one bit a cycle
            S_CLZ:
            begin
                if (!quo_reg[CB-1] && len_reg != 6'(CB - 1))
                begin
                    quo_next = {quo_reg[CB-2:0], 1'b0};
                    len_next = len_reg + 6'd1;
                end
                else
                begin
                    state_next = S_MASK;
                end
            end
            S_MASK:
            begin
                msk_next   = mask_from_len;
                end_next   = alu_res.value & ~mask_from_len;
                state_next = S_HIGH;
            end
            S_HIGH:
            begin
                tmp_next   = alu_res.value;
                state_next = S_CHECK;
            end
            // end value overshoots the interval: one more bit
            S_CHECK:
            begin
                if (alu_res.ge)
                begin
                    len_next   = len_reg + 6'd1;
                    msk_next   = msk_reg >> 1;
                    state_next = S_REMASK;
                end
                else
                begin
                    state_next = S_TAIL_LOOP;
                end
            end
            S_REMASK:
            begin
                end_next   = alu_res.value & ~msk_reg;
                state_next = S_TAIL_LOOP;
            end
            S_TAIL_LOOP:
            begin
                if (len_reg != '0)
                begin
                    c_next     = end_reg[CB-1:CB-SB-1];
                    ctx_next   = CTX_LOOP;
                    state_next = S_PUSH;
                end
                else
                begin
                    state_next = S_TAIL_FLUSH;
                end
            end
            // flush the carry buffer with a zero byte
            S_TAIL_FLUSH:
            begin
                if (held_valid_reg || pending_reg != '0)
                begin
                    c_next     = '0;
                    ctx_next   = CTX_TAIL;
                    state_next = S_PUSH;
                end
                else
                begin
                    state_next = S_CLEAR;
                end
            end
            // fresh stream
            S_CLEAR:
            begin
                low_next        = '0;
                range_next      = rec_pkg::CODE_TOP;
                held_next       = '0;
                held_valid_next = 1'b0;
                pending_next    = '0;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and coder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ctx_reg        <= CTX_RENORM;
            low_reg        <= '0;
            range_reg      <= rec_pkg::CODE_TOP;
            held_reg       <= '0;
            held_valid_reg <= 1'b0;
            pending_reg    <= '0;
            len_reg        <= '0;
            cnt_reg        <= '0;
            guard_reg      <= '0;
            ovalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ctx_reg        <= ctx_next;
            low_reg        <= low_next;
            range_reg      <= range_next;
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
            pending_reg    <= pending_next;
            len_reg        <= len_next;
            cnt_reg        <= cnt_next;
            guard_reg      <= guard_next;
            ovalid_reg     <= ovalid_next;
        end
    end

    // working and output payload
    always_ff @(posedge clk)
    begin
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        tmp_reg    <= tmp_next;
        end_reg    <= end_next;
        msk_reg    <= msk_next;
        c_reg      <= c_next;
        ft_reg     <= ft_next;
        k1_reg     <= k1_next;
        k2_reg     <= k2_next;
        fl_nz_reg  <= fl_nz_next;
        obyte_reg  <= obyte_next;
        ocount_reg <= ocount_next;
        olast_reg  <= olast_next;
    end

endmodule

// File: rtl/core/rec_checker.sv
// ----------------------------------------------------------------------------
// rec_checker: port-level checks for the range encoder
// Watches both channels and is bound to the top level.
// ----------------------------------------------------------------------------
module rec_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            item_valid,
    input logic                            item_ready,
    input logic [rec_pkg::OP_BITS-1:0]     item_op,
    input logic                            result_valid,
    input logic                            result_ready,
    input logic [rec_pkg::SYMBOL_BITS-1:0] result_byte,
    input logic [rec_pkg::COUNT_BITS-1:0]  result_count,
    input logic                            result_last
);

    // a stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_byte)
            && $stable(result_count) && $stable(result_last))
        else $error("result changed while stalled");

    // every result writes at least one byte
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result_count != '0)
        else $error("zero repeat count");

    // only a pending run carries a repeat count other than one
    a_run_byte: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_count != rec_pkg::COUNT_BITS'(1)
            |-> result_byte == rec_pkg::SYM_ZERO || result_byte == rec_pkg::SYM_MAX)
        else $error("run of a byte other than 0x00 or 0xFF");

    // a finish always keeps the encoder busy afterwards
    a_finish_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item_op == rec_pkg::OP_FINISH |=> !item_ready)
        else $error("ready right after a finish transfer");

endmodule

bind range_encoder_carry_buffered rec_checker u_rec_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .item_op      (item.op),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_byte  (result.byte_value),
    .result_count (result.repeat_count),
    .result_last  (result.last)
);

// File: tb/sv/rec_byte_checker.sv
// ----------------------------------------------------------------------------
// rec_byte_checker: output stream checker for the range encoder
// Watches both channels, keeps its own copy of the coder state and the carry
// buffer, predicts the byte transfers each accepted item causes and compares
// every result transfer, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rec_byte_checker
    import rec_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    rec_item_if    item,
    rec_result_if  result,
    output int     mismatches,
    output int     awaited
);

    localparam int MAX_BYTES_PER_ITEM = 10;

    typedef struct packed {
        logic [SYMBOL_BITS-1:0] byte_value;
        logic [COUNT_BITS-1:0]  repeat_count;
        logic                   last;
    } coded_byte_t;

    // predicted coder state
    logic [CODE_BITS-1:0]   model_low;
    logic [CODE_BITS-1:0]   model_range;
    logic [SYMBOL_BITS-1:0] model_held;
    logic                   model_held_ok;
    logic [COUNT_BITS-1:0]  model_pending;
    int                     item_bytes;

    coded_byte_t expected_bytes[$];

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    function automatic void reset_model();
        model_low     = '0;
        model_range   = CODE_TOP;
        model_held    = SYM_ZERO;
        model_held_ok = 1'b0;
        model_pending = '0;
    endfunction

    // at most ten predicted transfers are kept for one item
    function automatic void queue_byte(input logic [SYMBOL_BITS-1:0] value,
                                       input logic [COUNT_BITS-1:0] count);
        coded_byte_t entry;
        if (item_bytes < MAX_BYTES_PER_ITEM)
        begin
            entry.byte_value   = value;
            entry.repeat_count = count;
            entry.last         = 1'b0;
            expected_bytes.push_back(entry);
            item_bytes++;
        end
    endfunction

    // carry buffer: byte in the low bits, carry in bit 8
    function automatic void shift_out(input logic [SYMBOL_BITS:0] c);
        logic carry;
        carry = c[SYMBOL_BITS];
        if (c != {1'b0, SYM_MAX})
        begin
            if (model_held_ok)
                queue_byte(model_held + SYMBOL_BITS'(carry), 32'd1);
            if (model_pending != '0)
                queue_byte(SYM_MAX + SYMBOL_BITS'(carry), model_pending);
            model_pending = '0;
            model_held    = c[SYMBOL_BITS-1:0];
            model_held_ok = 1'b1;
        end
        else if (model_pending != '1)
        begin
            model_pending++;
        end
    endfunction

    // at most four renormalisation steps per symbol
    function automatic void renormalise();
        for (int step = 0; step < RENORM_STEPS && model_range <= CODE_BOT; step++)
        begin
            shift_out(model_low[CODE_BITS-1:CODE_BITS-SYMBOL_BITS-1]);
            model_low   = (model_low << SYMBOL_BITS) & LOW_MASK;
            model_range = model_range << SYMBOL_BITS;
        end
    endfunction

    // narrow the interval to the symbol's share; bad operands are ignored
    function automatic void encode_symbol(input logic [OP_BITS-1:0] op,
                                          input logic [FREQ_BITS-1:0] fl,
                                          input logic [FREQ_BITS-1:0] fh,
                                          input logic [FREQ_BITS-1:0] ft,
                                          input logic [LOG2_BITS-1:0] lg);
        logic [CODE_BITS-1:0] total;
        logic [CODE_BITS-1:0] share;
        if (op == OP_ENC_FREQ)
        begin
            if (ft == '0 || fh <= fl || fh > ft)
                return;
            total = {16'd0, ft};
            share = model_range / total;
        end
        else
        begin
            total = 32'd1 << lg;
            if (fh <= fl || {16'd0, fh} > total)
                return;
            share = model_range >> lg;
        end
        if (fl != '0)
        begin
            model_low   = model_low + model_range - share * (total - {16'd0, fl});
            model_range = share * ({16'd0, fh} - {16'd0, fl});
        end
        else
        begin
            model_range = model_range - share * (total - {16'd0, fh});
        end
        renormalise();
    endfunction

    // shortest tail, flush of the buffer, last flag on the final transfer
    function automatic void finish_stream();
        int                   zeros;
        logic [CODE_BITS-1:0] msk;
        logic [CODE_BITS-1:0] tail;
        coded_byte_t          final_byte;
        zeros = CODE_BITS;
        for (int b = 0; b < CODE_BITS; b++)
            if (model_range[b])
                zeros = CODE_BITS - 1 - b;
        if (zeros > CODE_BITS - 1)
            zeros = CODE_BITS - 1;
        msk  = LOW_MASK >> zeros;
        tail = (model_low + msk) & ~msk;
        if ((tail | msk) >= model_low + model_range)
        begin
            zeros++;
            msk  = msk >> 1;
            tail = (model_low + msk) & ~msk;
        end
        while (zeros > 0)
        begin
            shift_out(tail[CODE_BITS-1:CODE_BITS-SYMBOL_BITS-1]);
            tail  = (tail << SYMBOL_BITS) & LOW_MASK;
            zeros -= SYMBOL_BITS;
        end
        if (model_held_ok || model_pending != '0)
            shift_out('0);
        if (item_bytes > 0)
        begin
            final_byte      = expected_bytes.pop_back();
            final_byte.last = 1'b1;
            expected_bytes.push_back(final_byte);
        end
        reset_model();
    endfunction

    // predict on each item transfer, compare on each result transfer
    always @(posedge clk or negedge rst_n)
    begin
        coded_byte_t want;
        coded_byte_t got;
        if (!rst_n)
        begin
            reset_model();
            expected_bytes.delete();
            awaited = 0;
        end
        else
        begin
            if (item.valid && item.ready)
            begin
                item_bytes = 0;
                case (item.op)
                    OP_ENC_FREQ, OP_ENC_POW2:
                        encode_symbol(item.op, item.low_freq, item.high_freq,
                                      item.total_freq, item.total_log2);
                    OP_FINISH:
                        finish_stream();
                    default: ;
                endcase
            end
            if (result.valid && result.ready)
            begin
                got.byte_value   = result.byte_value;
                got.repeat_count = result.repeat_count;
                got.last         = result.last;
                if (expected_bytes.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected transfer byte %02h x%0d last %b",
                        got.byte_value, got.repeat_count, got.last));
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (got.byte_value !== want.byte_value)
                        report_mismatch($sformatf("byte_value %02h, expected %02h",
                            got.byte_value, want.byte_value));
                    if (got.repeat_count !== want.repeat_count)
                        report_mismatch($sformatf("repeat_count %0d, expected %0d",
                            got.repeat_count, want.repeat_count));
                    if (got.last !== want.last)
                        report_mismatch($sformatf("last %b, expected %b",
                            got.last, want.last));
                end
            end
            awaited = expected_bytes.size();
        end
    end

endmodule

// File: tb/sv/tb_range_encoder_carry_buffered.sv
// ----------------------------------------------------------------------------
// tb_range_encoder_carry_buffered: testbench top for the range encoder
// Drives directed corner items and then random symbol streams, each closed by
// a finish, under four idling phases on both channels; the byte checker
// predicts and compares, and this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_range_encoder_carry_buffered;

    import rec_pkg::*;

    localparam int CYCLE_LIMIT    = 400_000;
    localparam int SETTLE_CYCLES  = 80;
    localparam int RANDOM_SYMBOLS = 230;
    localparam int RESET_CYCLES   = 5;
    localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

    logic        clk   = 1'b0;
    logic        rst_n = 1'b0;
    int unsigned sender_idle_pct    = 0;
    int unsigned receiver_stall_pct = 0;
    int unsigned cycle_count        = 0;
    int          mismatches;
    int          awaited;

    rec_item_if   item_ch ();
    rec_result_if result_ch ();

    range_encoder_carry_buffered DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    rec_byte_checker stream_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item_ch),
        .result     (result_ch),
        .mismatches (mismatches),
        .awaited    (awaited)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver stalls at random
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            result_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    // one item transfer, with random idle cycles ahead of it
    task automatic send_item(input logic [OP_BITS-1:0] op,
                             input logic [FREQ_BITS-1:0] fl,
                             input logic [FREQ_BITS-1:0] fh,
                             input logic [FREQ_BITS-1:0] ft,
                             input logic [LOG2_BITS-1:0] lg);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.op         <= op;
        item_ch.low_freq   <= fl;
        item_ch.high_freq  <= fh;
        item_ch.total_freq <= ft;
        item_ch.total_log2 <= lg;
        do
            @(posedge clk);
        while (!item_ch.ready);
        @(negedge clk);
    endtask

    // hold off until every predicted byte has come, then let the block settle
    task automatic wait_for_drain();
        item_ch.valid <= 1'b0;
        while (awaited != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    // well-formed symbol, shaped towards the top, the bottom or anywhere
    task automatic send_random_symbol();
        logic [OP_BITS-1:0]   op;
        logic [LOG2_BITS-1:0] lg;
        logic [FREQ_BITS-1:0] ft;
        int unsigned          span;
        int unsigned          fl;
        int unsigned          fh;
        op = $urandom_range(0, 1) ? OP_ENC_POW2 : OP_ENC_FREQ;
        lg = LOG2_BITS'($urandom_range(0, 15));
        case ($urandom_range(0, 7))
            0, 1:    ft = FREQ_BITS'($urandom_range(1, 16));
            2:       ft = 16'hFFFF;
            default: ft = FREQ_BITS'($urandom_range(1, 65535));
        endcase
        span = (op == OP_ENC_FREQ) ? 32'(ft) : (32'd1 << lg);
        if (op == OP_ENC_POW2)
            ft = FREQ_BITS'($urandom_range(0, 65535));
        case ($urandom_range(0, 3))
            0:
            begin
                fl = span - 1;
                fh = span;
            end
            1:
            begin
                fl = 0;
                fh = $urandom_range(1, span);
            end
            default:
            begin
                fl = $urandom_range(0, span - 1);
                fh = $urandom_range(fl + 1, span);
            end
        endcase
        if (op == OP_ENC_FREQ)
            lg = LOG2_BITS'($urandom_range(0, 15));
        send_item(op, FREQ_BITS'(fl), FREQ_BITS'(fh), ft, lg);
    endtask

    // items the block takes and ignores
    task automatic send_noise();
        logic [FREQ_BITS-1:0] fl;
        fl = FREQ_BITS'($urandom_range(1, 65535));
        case ($urandom_range(0, 3))
            0: send_item(OP_UNUSED, FREQ_BITS'($urandom), FREQ_BITS'($urandom),
                         FREQ_BITS'($urandom), LOG2_BITS'($urandom));
            1: send_item(OP_ENC_FREQ, FREQ_BITS'($urandom), FREQ_BITS'($urandom), 16'd0,
                         LOG2_BITS'($urandom));
            2: send_item(OP_ENC_FREQ, fl, FREQ_BITS'($urandom_range(0, fl)), 16'hFFFF,
                         LOG2_BITS'($urandom));
            default: send_item(OP_ENC_POW2, 16'd0, FREQ_BITS'($urandom_range(2, 65535)),
                               FREQ_BITS'($urandom), 4'd0);
        endcase
    endtask

    function automatic void set_idling(input int phase);
        case (phase)
            0:
            begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 0;
            end
            1:
            begin
                sender_idle_pct    = 53;
                receiver_stall_pct = 0;
            end
            2:
            begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 53;
            end
            default:
            begin
                sender_idle_pct    = 15;
                receiver_stall_pct = 15;
            end
        endcase
    endfunction

    // stimulus and verdict
    initial
    begin
        int symbols_sent;
        int phase;
        int stream_len;

        item_ch.valid      = 1'b0;
        item_ch.op         = OP_ENC_FREQ;
        item_ch.low_freq   = '0;
        item_ch.high_freq  = '0;
        item_ch.total_freq = '0;
        item_ch.total_log2 = '0;
        set_idling(0);
        repeat (RESET_CYCLES)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // finish on an empty stream, then items that must be ignored
        send_item(OP_FINISH, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF);
        send_item(OP_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF);
        send_item(OP_ENC_FREQ, 16'd0, 16'd1, 16'd0, 4'd0);
        send_item(OP_ENC_FREQ, 16'd5, 16'd5, 16'd10, 4'd0);
        send_item(OP_ENC_FREQ, 16'd0, 16'd11, 16'd10, 4'd0);
        send_item(OP_ENC_POW2, 16'd0, 16'd9, 16'd0, 4'd3);
        send_item(OP_ENC_POW2, 16'd7, 16'd6, 16'd0, 4'd3);

        // extremes of the shares and the totals
        send_item(OP_ENC_FREQ, 16'd0, 16'hFFFF, 16'hFFFF, 4'd0);
        send_item(OP_ENC_FREQ, 16'hFFFE, 16'hFFFF, 16'hFFFF, 4'd0);
        send_item(OP_ENC_FREQ, 16'hFFFE, 16'hFFFF, 16'hFFFF, 4'd0);
        send_item(OP_ENC_FREQ, 16'hFFFE, 16'hFFFF, 16'hFFFF, 4'd0);
        send_item(OP_ENC_POW2, 16'd0, 16'd1, 16'd0, 4'd0);
        send_item(OP_ENC_POW2, 16'd0, 16'd1, 16'hFFFF, 4'd15);
        send_item(OP_ENC_POW2, 16'd32767, 16'd32768, 16'd0, 4'd15);
        send_item(OP_ENC_FREQ, 16'd0, 16'd1, 16'd1, 4'd0);
        send_item(OP_ENC_FREQ, 16'd0, 16'd1, 16'hFFFF, 4'd0);
        send_item(OP_FINISH, 16'd0, 16'd0, 16'd0, 4'd0);

        // top symbols build a run of 0xFF, then a carry may ripple into it
        repeat (4)
            send_item(OP_ENC_FREQ, 16'hFFFE, 16'hFFFF, 16'hFFFF, 4'd0);
        send_item(OP_ENC_POW2, 16'd1, 16'd2, 16'd0, 4'd15);
        send_item(OP_FINISH, 16'd0, 16'd0, 16'd0, 4'd0);
        send_item(OP_ENC_POW2, 16'd0, 16'd1, 16'd0, 4'd1);
        send_item(OP_FINISH, 16'd0, 16'd0, 16'd0, 4'd0);
        wait_for_drain();

        // random streams, four idling phases with a full drain between them
        symbols_sent = 0;
        phase        = 0;
        while (symbols_sent < RANDOM_SYMBOLS)
        begin
            if (symbols_sent * 4 / RANDOM_SYMBOLS != phase)
            begin
                phase = symbols_sent * 4 / RANDOM_SYMBOLS;
                wait_for_drain();
                set_idling(phase);
            end
            stream_len = $urandom_range(1, 24);
            for (int k = 0; k < stream_len; k++)
            begin
                if ($urandom_range(0, 11) == 0)
                    send_noise();
                send_random_symbol();
                symbols_sent++;
            end
            send_item(OP_FINISH, FREQ_BITS'($urandom), FREQ_BITS'($urandom),
                      FREQ_BITS'($urandom), LOG2_BITS'($urandom));
        end

        wait_for_drain();
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: files.f
rtl/core/rec_pkg.sv
rtl/core/rec_item_if.sv
rtl/core/rec_result_if.sv
rtl/core/rec_alu.sv
rtl/core/range_encoder_carry_buffered.sv
rtl/core/rec_checker.sv
tb/sv/rec_byte_checker.sv
tb/sv/tb_range_encoder_carry_buffered.sv
